// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Entry depth, request kinds, status codes and the cell link and op structs.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Number of entries held by the queue (one cell each)
    localparam int unsigned DEPTH   = 16;
    // Width of the entry counter, able to hold DEPTH itself
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned DATA_W  = 32;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // What a cell holds, as seen by its neighbours
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } cell_link_t;

    // Operation applied to every cell of the row at once
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } cell_op_t;

endpackage

// ===== rtl/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell: one entry of the double-ended queue
// Holds a value and a valid bit. Shifts towards the back on a front push,
// towards the front on a front pop, and fills or empties itself at the back.
// ----------------------------------------------------------------------------
module deq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::cell_op_t  op,
    input  logic signed [31:0] push_value,
    input  deq_pkg::cell_link_t left,
    input  deq_pkg::cell_link_t right,
    output deq_pkg::cell_link_t cell_q,
    output logic signed [31:0] back_part
);
    import deq_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     is_back;

    // Next contents from the row operation and the neighbours
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (op.push_front)
        begin
            valid_next = left.valid;
            data_next  = left.data;
        end
        else if (op.push_back)
        begin
            // first empty cell after the occupied run takes the value
            if (!valid_reg && left.valid)
            begin
                valid_next = 1'b1;
                data_next  = push_value;
            end
        end
        else if (op.pop_front)
        begin
            valid_next = right.valid;
            data_next  = right.data;
        end
        else if (op.pop_back)
        begin
            if (is_back)
            begin
                valid_next = 1'b0;
            end
        end
        else
        begin
            // no request this cycle: hold
            valid_next = valid_reg;
            data_next  = data_reg;
        end
    end

    // Valid bit is control state; data needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // This cell is the back when it holds a value and its right neighbour does not
    assign is_back   = valid_reg && !right.valid;
    assign back_part = is_back ? data_reg : '0;

    assign cell_q.valid = valid_reg;
    assign cell_q.data  = data_reg;

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// A row of cells, cell 0 at the front, each holding one entry in order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries kind and push_value:
//   push front, push back, pop front or pop back. Each request gives exactly
//   one result beat on the response channel (rsp_valid / rsp_stall) with the
//   popped value, a status (ok, pop on empty, push on full), the entry count
//   and the values now at the front and the back (zero when empty).
//   The result appears in the cycle after the request beat. Throughput is one
//   request per cycle while the receiver does not stall; every cell updates from
//   its neighbours in the same cycle, so the row shift sets the rate.
//   When the receiver stalls, the result is held and req_stall is raised
//   until the result beat is taken; a new request may be taken in the same
//   cycle as the pending result leaves.
//   Reset clears every valid bit and the count, leaving the queue empty with
//   no result pending. Rejected pushes and pops leave the contents untouched.
// ----------------------------------------------------------------------------
module double_ended_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] push_value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] popped_value,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value
);
    import deq_pkg::*;

    cell_link_t               cell_q    [DEPTH];
    logic signed [DATA_W-1:0] back_part [DEPTH];
    cell_link_t               head_link;
    cell_link_t               tail_link;
    cell_op_t                 op;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic signed [DATA_W-1:0] back_now;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [CNT_W+4:0]         count_ext;

    // Handshake: take a request when no result is waiting or it leaves now
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign is_full  = cell_q[DEPTH-1].valid;
    assign is_empty = !cell_q[0].valid;

    // Ends of the row
    assign head_link.valid = 1'b1;
    assign head_link.data  = push_value;
    assign tail_link.valid = 1'b0;
    assign tail_link.data  = '0;

    // Current back value: only the back cell, if any, drives a non-zero part
    always_comb
    begin
        back_now = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_now = back_now | back_part[i];
        end
    end

    // Request decode, result and count update
    always_comb
    begin
        op             = '0;
        count_next     = count_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            popped_next    = '0;
            status_next    = STATUS_OK;
            unique case (kind_t'(kind))
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        op.push_front = (kind_t'(kind) == KIND_PUSH_FRONT);
                        op.push_back  = (kind_t'(kind) == KIND_PUSH_BACK);
                        count_next    = count_reg + 1'b1;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        op.pop_front = (kind_t'(kind) == KIND_POP_FRONT);
                        op.pop_back  = (kind_t'(kind) == KIND_POP_BACK);
                        popped_next  = (kind_t'(kind) == KIND_POP_FRONT) ?
                                       cell_q[0].data : back_now;
                        count_next   = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        deq_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .push_value (push_value),
            .left       ((g == 0) ? head_link : cell_q[(g == 0) ? 0 : g - 1]),
            .right      ((g == DEPTH - 1) ? tail_link :
                         cell_q[(g == DEPTH - 1) ? DEPTH - 1 : g + 1]),
            .cell_q     (cell_q[g]),
            .back_part  (back_part[g])
        );
    end

    // Outputs; the cells only move when a request is taken
    assign count_ext    = {5'd0, count_reg};
    assign rsp_valid    = rsp_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign entry_count  = count_ext[4:0];
    assign front_value  = cell_q[0].valid ? cell_q[0].data : '0;
    assign back_value   = back_now;

endmodule
